### src/lcsg_pkg.sv
// shared constants, types and the quarter-wave sine table for the chirp generator
// no dependencies; used by every module of the block except lcsg_ram
package lcsg_pkg;

  localparam int PHASE_WIDTH = 32;
  localparam int SINE_TABLE_BITS = 10;
  localparam int QTR_DEPTH = 1 << SINE_TABLE_BITS;
  localparam int IDX_W = SINE_TABLE_BITS + 2;
  localparam int FREQ_W = 31;
  localparam int CUR_W = 32;
  localparam int AMP_W = 16;
  localparam int SAMPLE_W = 16;
  localparam int MAG_W = 15;
  localparam int PROD_W = MAG_W + AMP_W;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_ADDR_W-1:0] REG_AMPLITUDE = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_START_FREQ = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_END_FREQ = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_FREQ_STEP = 2'd3;

  localparam logic [MAG_W-1:0] SINE_MAX = 15'd32767;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             play;
    logic             active;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef logic [MAG_W-1:0] rom_t [QTR_DEPTH];

  function automatic logic [MAG_W-1:0] quarter_entry(input int unsigned k);
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] y2;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] s;
    x = 64'(k) << (30 - SINE_TABLE_BITS);
    y = (x * HALF_PI_Q30) >> 30;
    y2 = (y * y) >> 30;
    pos = y;
    term = ((y * y2) >> 30) / 64'd6;
    neg = term;
    term = ((term * y2) >> 30) / 64'd20;
    pos = pos + term;
    term = ((term * y2) >> 30) / 64'd42;
    neg = neg + term;
    term = ((term * y2) >> 30) / 64'd72;
    pos = pos + term;
    term = ((term * y2) >> 30) / 64'd110;
    neg = neg + term;
    term = ((term * y2) >> 30) / 64'd156;
    pos = pos + term;
    s = (pos > neg) ? pos - neg : 64'd0;
    s = (s * 64'd32767 + 64'd536870912) >> 30;
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    return s[MAG_W-1:0];
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i < QTR_DEPTH; i++) begin
      r[i] = quarter_entry(i);
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // frequency word scaled onto the phase accumulator width
  function automatic logic [PHASE_WIDTH-1:0] freq_to_phase(input logic [CUR_W-1:0] f);
    logic [PHASE_WIDTH+CUR_W-1:0] t;
    t = {f, {PHASE_WIDTH{1'b0}}};
    return t[PHASE_WIDTH+CUR_W-1:CUR_W];
  endfunction

endpackage

### src/lcsg_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module lcsg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/lcsg_front.sv
// sweep state: phase accumulator, current frequency, direction and busy flag
// depends on lcsg_pkg; pushes one command per accepted item into the queue
module lcsg_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic                      restart,
  input  logic [lcsg_pkg::FREQ_W-1:0] start_freq,
  input  logic [lcsg_pkg::FREQ_W-1:0] end_freq,
  input  logic [lcsg_pkg::FREQ_W-1:0] freq_step,
  input  lcsg_pkg::q_status_t       q_status,
  input  logic                      table_ready,
  output logic                      push,
  output lcsg_pkg::cmd_t            cmd
);
  import lcsg_pkg::*;

  logic [PHASE_WIDTH-1:0] phase_acc;
  logic [PHASE_WIDTH-1:0] phase_acc_next;
  logic [CUR_W-1:0]       current_freq;
  logic [CUR_W-1:0]       current_freq_next;
  logic                   busy;
  logic                   busy_next;
  logic                   sweep_down;
  logic                   sweep_down_next;

  logic [PHASE_WIDTH-1:0] ph0;
  logic [CUR_W-1:0]       cf0;
  logic [CUR_W-1:0]       end_ext;
  logic [CUR_W-1:0]       step_ext;
  logic                   busy0;
  logic                   stop;

  assign s_tready = table_ready & ~q_status.full;
  assign push = s_tvalid & s_tready;
  assign end_ext = {1'b0, end_freq};
  assign step_ext = {1'b0, freq_step};

  always_comb begin
    ph0 = restart ? '0 : phase_acc;
    cf0 = restart ? {1'b0, start_freq} : current_freq;
    sweep_down_next = restart ? (end_freq < start_freq) : sweep_down;
    busy0 = restart | busy;
    stop = sweep_down_next ? ((cf0 < end_ext) || (cf0 < step_ext)) : (cf0 > end_ext);
    busy_next = busy0;
    current_freq_next = cf0;
    phase_acc_next = ph0;
    if (busy0) begin
      if (stop) begin
        busy_next = 1'b0;
      end else begin
        current_freq_next = sweep_down_next ? cf0 - step_ext : cf0 + step_ext;
        phase_acc_next = ph0 + freq_to_phase(current_freq_next);
      end
    end
    cmd.idx = ph0[PHASE_WIDTH-1 -: IDX_W];
    cmd.play = busy0;
    cmd.active = busy_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
      current_freq <= '0;
      busy <= 1'b0;
      sweep_down <= 1'b0;
    end else if (push) begin
      phase_acc <= phase_acc_next;
      current_freq <= current_freq_next;
      busy <= busy_next;
      sweep_down <= sweep_down_next;
    end
  end

endmodule

### src/lcsg_queue.sv
// short command queue between the sweep front and the sine back end
// depends on lcsg_pkg
module lcsg_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  lcsg_pkg::cmd_t      wdata,
  input  logic                pop,
  output lcsg_pkg::cmd_t      rdata,
  output lcsg_pkg::q_status_t status
);
  import lcsg_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign rdata = entries[rd_ptr];
  assign status.full = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (!push && pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### src/lcsg_back.sv
// sine lookup, gain and output register; loads the quarter-wave ram after reset
// depends on lcsg_pkg and lcsg_ram
module lcsg_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [lcsg_pkg::AMP_W-1:0]   amplitude,
  input  lcsg_pkg::cmd_t               head,
  input  lcsg_pkg::q_status_t          q_status,
  output logic                         pop,
  output logic                         table_ready,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [lcsg_pkg::SAMPLE_W-1:0] sample,
  output logic                         active
);
  import lcsg_pkg::*;

  logic [SINE_TABLE_BITS:0]   fill_addr;
  logic                       en;
  logic                       odd;
  logic [SINE_TABLE_BITS-1:0] k;
  logic [SINE_TABLE_BITS-1:0] raddr;
  logic [MAG_W-1:0]           rdata;
  logic [MAG_W-1:0]           mag;

  logic                       v1;
  logic                       play1;
  logic                       act1;
  logic                       neg1;
  logic                       top1;
  logic                       v2;
  logic                       play2;
  logic                       act2;
  logic                       neg2;
  logic [PROD_W-1:0]          prod2;
  logic [PROD_W-1:0]          rounded;
  logic [SAMPLE_W-1:0]        sample_next;

  assign table_ready = fill_addr[SINE_TABLE_BITS];
  assign en = ~m_tvalid | m_tready;
  assign pop = en & ~q_status.empty;

  assign odd = head.idx[SINE_TABLE_BITS];
  assign k = head.idx[SINE_TABLE_BITS-1:0];
  assign raddr = odd ? SINE_TABLE_BITS'(0) - k : k;
  assign mag = top1 ? SINE_MAX : rdata;

  lcsg_ram #(
    .WIDTH(MAG_W),
    .DEPTH(QTR_DEPTH)
  ) u_sine_ram (
    .clk  (clk),
    .we   (~table_ready),
    .waddr(fill_addr[SINE_TABLE_BITS-1:0]),
    .wdata(SINE_ROM[fill_addr[SINE_TABLE_BITS-1:0]]),
    .re   (en),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_addr <= '0;
    end else if (!table_ready) begin
      fill_addr <= fill_addr + 1'b1;
    end
  end

  always_comb begin
    rounded = (prod2 + PROD_W'(16384)) >> 15;
    if (!play2) begin
      sample_next = '0;
    end else if (neg2) begin
      sample_next = (rounded > PROD_W'(32768)) ? 16'sh8000 : SAMPLE_W'(-rounded);
    end else begin
      sample_next = (rounded > PROD_W'(32767)) ? 16'h7fff : rounded[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      v1 <= pop;
      v2 <= v1;
      m_tvalid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      play1 <= head.play;
      act1 <= head.active;
      neg1 <= head.idx[SINE_TABLE_BITS+1];
      top1 <= odd && (k == '0);
      play2 <= play1;
      act2 <= act1;
      neg2 <= neg1;
      prod2 <= PROD_W'(mag) * PROD_W'(amplitude);
      sample <= sample_next;
      active <= act2;
    end
  end

endmodule

### src/linear_chirp_sine_generator_core.sv
// Linear chirp sine generator. Each accepted input item is one sample tick and yields one
// output item: a sine sample of a linear frequency sweep and the busy flag after it. The
// block takes one item per clock cycle while the sine table is loaded and the command
// queue is not full; a four-entry command queue between the phase and frequency update
// loop and the table and gain pipeline lets either side stall alone. After reset the
// 1024-entry quarter-wave table ram is loaded, during which no item is accepted;
// configuration writes are taken at any time.
// depends on lcsg_pkg, lcsg_front, lcsg_queue, lcsg_back
module linear_chirp_sine_generator_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [lcsg_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [lcsg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,  // [0] restart, rest unused
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [23:0]                    m_tdata   // [15:0] sample, [16] active, rest zero
);
  import lcsg_pkg::*;

  logic [AMP_W-1:0]    amplitude;
  logic [FREQ_W-1:0]   start_freq;
  logic [FREQ_W-1:0]   end_freq;
  logic [FREQ_W-1:0]   freq_step;

  q_status_t           q_status;
  cmd_t                push_cmd;
  cmd_t                head;
  logic                push;
  logic                pop;
  logic                table_ready;
  logic [SAMPLE_W-1:0] sample;
  logic                active;

  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude <= '0;
      start_freq <= '0;
      end_freq <= '0;
      freq_step <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_AMPLITUDE:  amplitude <= cfg_data[AMP_W-1:0];
        REG_START_FREQ: start_freq <= cfg_data[FREQ_W-1:0];
        REG_END_FREQ:   end_freq <= cfg_data[FREQ_W-1:0];
        REG_FREQ_STEP:  freq_step <= cfg_data[FREQ_W-1:0];
        default: ;
      endcase
    end
  end

  lcsg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .restart    (s_tdata[0]),
    .start_freq (start_freq),
    .end_freq   (end_freq),
    .freq_step  (freq_step),
    .q_status   (q_status),
    .table_ready(table_ready),
    .push       (push),
    .cmd        (push_cmd)
  );

  lcsg_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_cmd),
    .pop   (pop),
    .rdata (head),
    .status(q_status)
  );

  lcsg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .amplitude  (amplitude),
    .head       (head),
    .q_status   (q_status),
    .pop        (pop),
    .table_ready(table_ready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .sample     (sample),
    .active     (active)
  );

  assign m_tdata = {7'd0, active, sample};

`ifndef SYNTH
  a_no_accept_while_loading: assert property (@(posedge clk) !table_ready |-> !s_tready)
    else $error("item accepted while sine table loads");
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_status.full)
    else $error("command queue overflow");
  a_load_after_reset: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input ready right after reset");
  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("command queue underflow");
`endif

endmodule

### sim/linear_chirp_sine_generator_core_test.sv
// self-checking testbench for linear_chirp_sine_generator_core: sweeps are configured,
// ticks are streamed in, and every output item is checked against a sweep predictor
// depends on lcsg_pkg and linear_chirp_sine_generator_core
module linear_chirp_sine_generator_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PW = lcsg_pkg::PHASE_WIDTH;
  localparam int TBITS = lcsg_pkg::SINE_TABLE_BITS;
  localparam int QDEPTH = 1 << TBITS;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               active;
  } tone_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [lcsg_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [lcsg_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [0] restart
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // [15:0] sample, [16] active

  // shadow registers and sweep state
  logic [15:0]   amp_reg = '0;
  logic [30:0]   start_reg = '0;
  logic [30:0]   end_reg = '0;
  logic [30:0]   step_reg = '0;
  logic [PW-1:0] phase = '0;
  logic [31:0]   cur_freq = '0;
  logic          busy = 1'b0;
  logic          down = 1'b0;

  int unsigned quarter_mag [QDEPTH+1];
  bit          tick_q [$];
  tone_t       expected_tones [$];
  int          n_sent = 0;
  int          n_mismatch = 0;
  int          n_cycles = 0;

  linear_chirp_sine_generator_core u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int unsigned taylor_sine(input int k);
    longint unsigned x, y, y2, term, pos, neg, s;
    if (k >= QDEPTH) return 32767;
    x = longint'(k) << (30 - TBITS);
    y = (x * HALF_PI_Q30) >> 30;
    y2 = (y * y) >> 30;
    term = y;
    pos = y;
    neg = 0;
    for (int n = 3; n <= 13; n += 2) begin
      term = ((term * y2) >> 30) / longint'((n - 1) * n);
      if (((n - 1) / 2) % 2 == 1) neg += term;
      else pos += term;
    end
    s = (pos > neg) ? pos - neg : 0;
    s = (s * 32767 + (64'd1 << 29)) >> 30;
    if (s > 32767) s = 32767;
    return int'(s);
  endfunction

  function automatic logic [PW-1:0] phase_step(input logic [31:0] f);
    logic [95:0] w;
    w = {64'd0, f};
    if (PW >= 32) w = w << (PW - 32);
    else w = w >> (32 - PW);
    return w[PW-1:0];
  endfunction

  function automatic tone_t next_tone(input logic restart);
    logic [TBITS+1:0] idx;
    int unsigned      mag;
    longint unsigned  prod;
    longint           lvl;
    tone_t            t;
    if (restart) begin
      phase = '0;
      cur_freq = {1'b0, start_reg};
      down = end_reg < start_reg;
      busy = 1'b1;
    end
    t.sample = '0;
    if (busy) begin
      idx = phase[PW-1 -: TBITS+2];
      if (idx[TBITS]) mag = quarter_mag[QDEPTH - int'(idx[TBITS-1:0])];
      else mag = quarter_mag[int'(idx[TBITS-1:0])];
      prod = longint'(mag) * longint'(amp_reg);
      lvl = longint'((prod + 16384) >> 15);
      if (idx[TBITS+1]) lvl = -lvl;
      if (lvl > 32767) lvl = 32767;
      if (lvl < -32768) lvl = -32768;
      t.sample = lvl[15:0];
      if (!down) begin
        if (cur_freq > end_reg) begin
          busy = 1'b0;
        end else begin
          cur_freq = cur_freq + step_reg;
          phase = phase + phase_step(cur_freq);
        end
      end else begin
        if (cur_freq < end_reg || cur_freq < step_reg) begin
          busy = 1'b0;
        end else begin
          cur_freq = cur_freq - step_reg;
          phase = phase + phase_step(cur_freq);
        end
      end
    end
    t.active = busy;
    return t;
  endfunction

  function automatic int idle_pct(input bit sender);
    if (n_sent < 200) return sender ? 16 : 84;
    if (n_sent < 400) return sender ? 84 : 16;
    return 0;
  endfunction

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // tick driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_tones.push_back(next_tone(s_tdata[0]));
        n_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (tick_q.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
          s_tdata <= {7'd0, tick_q.pop_front()};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // sample monitor
  always @(posedge clk) begin
    tone_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_tones.size() == 0) begin
          if (n_mismatch < 10)
            $display("unexpected item: sample %0d active %0b",
                     $signed(m_tdata[15:0]), m_tdata[16]);
          n_mismatch++;
        end else begin
          want = expected_tones.pop_front();
          if (m_tdata[15:0] !== want.sample || m_tdata[16] !== want.active) begin
            if (n_mismatch < 10)
              $display("expected sample %0d active %0b, got sample %0d active %0b",
                       want.sample, want.active, $signed(m_tdata[15:0]), m_tdata[16]);
            n_mismatch++;
          end
        end
      end
      m_tready <= $urandom_range(99) >= idle_pct(1'b0);
    end
  end

  task automatic wait_drained();
    while (tick_q.size() != 0 || s_tvalid || expected_tones.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [lcsg_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [30:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    case (addr)
      lcsg_pkg::REG_AMPLITUDE:  amp_reg = data[15:0];
      lcsg_pkg::REG_START_FREQ: start_reg = data;
      lcsg_pkg::REG_END_FREQ:   end_reg = data;
      lcsg_pkg::REG_FREQ_STEP:  step_reg = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_sweep(input logic [15:0] amp, input logic [30:0] f0,
                           input logic [30:0] f1, input logic [30:0] df);
    wait_drained();
    write_reg(lcsg_pkg::REG_AMPLITUDE, 31'(amp));
    write_reg(lcsg_pkg::REG_START_FREQ, f0);
    write_reg(lcsg_pkg::REG_END_FREQ, f1);
    write_reg(lcsg_pkg::REG_FREQ_STEP, df);
  endtask

  task automatic push_run(input int len, input bit lead_restart);
    tick_q.push_back(lead_restart);
    repeat (len - 1) tick_q.push_back(1'b0);
  endtask

  initial begin
    int          n_queued;
    int          len;
    logic [15:0] amp;
    logic [30:0] f0, f1, df, span;
    for (int k = 0; k <= QDEPTH; k++) quarter_mag[k] = taylor_sine(k);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // idle ticks straight after reset
    push_run(2, 1'b0);
    // steady tone through the first two quadrants
    set_sweep(16'd32768, 31'h1000_0000, 31'h7fff_ffff, 31'd0);
    push_run(8, 1'b1);
    // down sweep that ends below the step, gain saturating
    set_sweep(16'hffff, 31'h7fff_ffff, 31'd0, 31'h3fff_ffff);
    push_run(5, 1'b1);
    // up sweep that passes the end word
    set_sweep(16'd32767, 31'd0, 31'h7fff_ffff, 31'h4000_0000);
    push_run(4, 1'b1);
    set_sweep(16'd0, 31'd0, 31'd0, 31'h7fff_ffff);
    push_run(3, 1'b1);
    // down sweep that ends below the end word
    set_sweep(16'd20000, 31'd1000, 31'd500, 31'd300);
    push_run(4, 1'b1);
    n_queued = 26;

    while (n_queued < 626) begin
      case ($urandom_range(5))
        0: amp = 16'd0;
        1: amp = 16'd32768;
        2: amp = 16'hffff;
        default: amp = 16'($urandom_range(65535));
      endcase
      f0 = 31'($urandom);
      f1 = ($urandom_range(7) == 0) ? f0 : 31'($urandom);
      span = (f1 > f0) ? f1 - f0 : f0 - f1;
      case ($urandom_range(9))
        0: df = 31'd0;
        1: df = 31'($urandom);
        default: df = span / 31'($urandom_range(60, 2));
      endcase
      set_sweep(amp, f0, f1, df);
      len = $urandom_range(70, 20);
      for (int i = 0; i < len; i++)
        tick_q.push_back(i == 0 ? ($urandom_range(7) != 0) : ($urandom_range(24) == 0));
      n_queued += len;
    end

    wait_drained();
    repeat (12) @(posedge clk);
    if (n_mismatch == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### filelist.f
src/lcsg_pkg.sv
src/lcsg_ram.sv
src/lcsg_front.sv
src/lcsg_queue.sv
src/lcsg_back.sv
src/linear_chirp_sine_generator_core.sv
sim/linear_chirp_sine_generator_core_test.sv
